// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the polygon plane splitter
// Item layouts, side and status codes, widths and saturation helpers.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_VERTS  = 16;
  localparam int SPLIT_SPAN = 240;
  localparam int ADDR_W     = $clog2(MAX_VERTS);
  localparam int CNT_W      = $clog2(MAX_VERTS + 1);
  localparam int LCNT_W     = $clog2(3 * MAX_VERTS + 1);

  localparam logic signed [48:0] SPAN_LIMIT = 49'(SPLIT_SPAN * 65536);
  localparam logic signed [48:0] PLANE_OFS  = 49'((SPLIT_SPAN - 16) * 65536);
  localparam logic signed [47:0] EPS_POS    = 48'sd6554;
  localparam logic signed [47:0] EPS_NEG    = -48'sd6554;
  localparam logic signed [17:0] ONE_POS    = 18'sd65536;
  localparam logic signed [17:0] ONE_NEG    = -18'sd65536;
  localparam logic signed [47:0] S48_MAX    = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [31:0] S32_MAX    = 32'sh7FFF_FFFF;

  localparam logic [1:0] SIDE_ON    = 2'd0;
  localparam logic [1:0] SIDE_FRONT = 2'd1;
  localparam logic [1:0] SIDE_BACK  = 2'd2;

  localparam logic [2:0] ST_SPLIT = 3'd0;
  localparam logic [2:0] ST_FEW   = 3'd1;
  localparam logic [2:0] ST_SPAN  = 3'd2;
  localparam logic [2:0] ST_ONE   = 3'd3;
  localparam logic [2:0] ST_THIN  = 3'd4;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               last_vertex;
  } vert_t;

  typedef struct packed {
    logic               side;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [2:0]  status;
    logic               last_result;
  } res_t;

  // Command to the shared divide / square root unit.
  typedef struct packed {
    logic        start;
    logic        sqrt_mode;
    logic [49:0] rem_init;
    logic [64:0] dividend;
    logic [48:0] divisor;
    logic [6:0]  steps;
  } dv_cmd_t;

  function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
    if (v > $signed({3'b000, S48_MAX})) begin
      return S48_MAX;
    end else if (v < $signed({3'b111, ~S48_MAX})) begin
      return ~S48_MAX;
    end else begin
      return v[47:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > $signed({17'h00000, S32_MAX})) begin
      return S32_MAX;
    end else if (v < $signed({17'h1FFFF, ~S32_MAX})) begin
      return ~S32_MAX;
    end else begin
      return v[31:0];
    end
  endfunction

  // An edge crosses the plane when both ends are off the plane on opposite sides.
  function automatic logic crosses(input logic [1:0] a, input logic [1:0] b);
    return (a != SIDE_ON) && (b != SIDE_ON) && (a != b);
  endfunction

endpackage

// ===== hw/rtl/pps_divsqrt.sv =====
// ----------------------------------------------------------------------------
// pps_divsqrt: shared iterative divide and square root unit
// Restoring divide (one quotient bit per cycle) or integer square root
// (one root bit per cycle) on a common compare and subtract datapath.
// ----------------------------------------------------------------------------
module pps_divsqrt (
  input  logic              clk,
  input  logic              rst,
  input  pps_pkg::dv_cmd_t  cmd,
  output logic              done,
  output logic [64:0]       quot
);
  import pps_pkg::*;

  logic        busy;
  logic [6:0]  left;
  logic [49:0] rem;
  logic [64:0] dq;
  logic [48:0] dvs;
  logic        mode;
  logic [50:0] sh;
  logic [50:0] sub;
  logic [50:0] diff;
  logic        ge;

  always_comb begin
    if (mode) begin
      sh  = {rem[48:0], dq[64:63]};
      sub = {quot[48:0], 2'b01};
    end else begin
      sh  = {rem, dq[64]};
      sub = {2'b00, dvs};
    end
    ge   = (sh >= sub);
    diff = sh - sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        left <= cmd.steps;
        rem  <= cmd.rem_init;
        dq   <= cmd.dividend;
        dvs  <= cmd.divisor;
        mode <= cmd.sqrt_mode;
        quot <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[49:0] : sh[49:0];
        dq   <= mode ? {dq[62:0], 2'b00} : {dq[63:0], 1'b0};
        quot <= {quot[63:0], ge};
        left <= left - 7'd1;
        if (left == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/polygon_plane_split_top.sv =====
// ----------------------------------------------------------------------------
// Loading: one vertex per cycle while vert_ready is high; the final vertex starts
// the split, which runs on through the crossing edges and the result items until
// its last result item is taken.
// Throughput: one polygon at a time, set by the shared multiplier and the
// bit-serial divide / square root unit; each result waits until it is taken.
// Reset: synchronous; clears the sequencer state and vertex count, no clearing pass.
// ----------------------------------------------------------------------------
module polygon_plane_split_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           vert_valid,
  output logic           vert_ready,
  input  pps_pkg::vert_t vert_item,
  output logic           res_valid,
  input  logic           res_ready,
  output pps_pkg::res_t  res_item
);
  import pps_pkg::*;

  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_PJ_ADDR  = 5'd1;
  localparam logic [4:0] S_PJ_WAIT  = 5'd2;
  localparam logic [4:0] S_PJ_MUL   = 5'd3;
  localparam logic [4:0] S_PJ_ACC   = 5'd4;
  localparam logic [4:0] S_PJ_DONE  = 5'd5;
  localparam logic [4:0] S_SPAN_CHK = 5'd6;
  localparam logic [4:0] S_SQ_MUL   = 5'd7;
  localparam logic [4:0] S_SQ_ACC   = 5'd8;
  localparam logic [4:0] S_SQRT     = 5'd9;
  localparam logic [4:0] S_NRM      = 5'd10;
  localparam logic [4:0] S_DIST     = 5'd11;
  localparam logic [4:0] S_CL_END   = 5'd12;
  localparam logic [4:0] S_CL_CHK   = 5'd13;
  localparam logic [4:0] S_EM_ADDR  = 5'd14;
  localparam logic [4:0] S_EM_W1    = 5'd15;
  localparam logic [4:0] S_EM_CUR   = 5'd16;
  localparam logic [4:0] S_EM_W2    = 5'd17;
  localparam logic [4:0] S_EM_SELF  = 5'd18;
  localparam logic [4:0] S_EM_X     = 5'd19;
  localparam logic [4:0] S_FRAC     = 5'd20;
  localparam logic [4:0] S_MID_MUL  = 5'd21;
  localparam logic [4:0] S_MID_ACC  = 5'd22;
  localparam logic [4:0] S_EM_MID   = 5'd23;
  localparam logic [4:0] S_EM_NEXT  = 5'd24;
  localparam logic [4:0] S_OWAIT    = 5'd25;

  localparam logic [6:0] SQRT_STEPS = 7'd32;
  localparam logic [6:0] NRM_STEPS  = 7'd48;
  localparam logic [6:0] DIST_STEPS = 7'd65;
  localparam logic [6:0] FRAC_STEPS = 7'd16;

  logic [4:0] state, ret;
  logic [CNT_W-1:0] vcount, nv, vcount_inc, last_idx, idx_inc;
  logic [ADDR_W-1:0] idx, ra, nx;
  logic [1:0] j;
  logic pmode, lst, dv_run;

  logic signed [31:0] ax, ay, az;
  logic signed [31:0] vx_mem [MAX_VERTS];
  logic signed [31:0] vy_mem [MAX_VERTS];
  logic signed [31:0] vz_mem [MAX_VERTS];
  logic signed [47:0] dist_mem [MAX_VERTS];
  logic [1:0] side_mem [MAX_VERTS];
  logic signed [31:0] rx, ry, rz;
  logic signed [47:0] rd_d;
  logic [1:0] rs;

  logic signed [50:0] acc;
  logic signed [47:0] mn, mx, plane_d;
  logic [63:0] sq;
  logic [31:0] len;
  logic signed [17:0] nrm_x, nrm_y, nrm_z;
  logic [LCNT_W-1:0] cnt0, cnt1, k, total;
  logic fseen, bseen;
  logic [1:0] prev_side, first_side;
  logic signed [31:0] cur_x, cur_y, cur_z;
  logic signed [47:0] cur_d;
  logic [1:0] cur_s;
  logic [15:0] frac;
  logic signed [31:0] mid_x, mid_y, mid_z;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  dv_cmd_t dv_cmd;
  logic dv_done;
  logic [64:0] dv_quot;

  logic signed [31:0] axis_j, vsel, cur_j, mid_j;
  logic signed [17:0] nrm_j;
  logic [31:0] axis_mag;
  logic signed [47:0] pv, dval, dpos;
  logic [1:0] cl_side;
  logic pair_x, own, is_last;
  logic signed [48:0] span_w, t_w;
  logic [48:0] tmag;
  logic [47:0] num, nmag;
  logic [48:0] den;
  logic ld_we, cl_we;

  pps_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .cmd  (dv_cmd),
    .done (dv_done),
    .quot (dv_quot)
  );

  assign vert_ready = (state == S_LOAD);
  assign vcount_inc = (vcount < CNT_W'(MAX_VERTS)) ? vcount + 1'b1 : vcount;
  assign last_idx   = nv - 1'b1;
  assign idx_inc    = CNT_W'(idx) + 1'b1;
  assign nx         = (idx_inc < nv) ? idx_inc[ADDR_W-1:0] : '0;
  assign is_last    = (k == total - 1'b1);

  always_comb begin
    case (j)
      2'd0: begin
        axis_j = ax; vsel = rx; cur_j = cur_x; nrm_j = nrm_x;
      end
      2'd1: begin
        axis_j = ay; vsel = ry; cur_j = cur_y; nrm_j = nrm_y;
      end
      default: begin
        axis_j = az; vsel = rz; cur_j = cur_z; nrm_j = nrm_z;
      end
    endcase
    axis_mag = axis_j[31] ? 32'(-axis_j) : axis_j;
  end

  always_comb begin
    pv      = sat48(acc);
    dval    = sat48({{3{pv[47]}}, pv} - {{3{plane_d[47]}}, plane_d});
    cl_side = (dval < EPS_NEG) ? SIDE_BACK : ((dval > EPS_POS) ? SIDE_FRONT : SIDE_ON);
    pair_x  = (idx != '0) && crosses(prev_side, cl_side);
    own     = (cur_s == SIDE_ON) || (cur_s == (lst ? SIDE_BACK : SIDE_FRONT));
    span_w  = $signed({mx[47], mx}) - $signed({mn[47], mn});
    t_w     = $signed({mn[47], mn}) + PLANE_OFS;
    tmag    = t_w[48] ? 49'(-t_w) : t_w;
    dpos    = (|dv_quot[64:47]) ? S48_MAX : $signed({1'b0, dv_quot[46:0]});
    num     = cur_d[47] ? 48'(-cur_d) : cur_d;
    nmag    = rd_d[47] ? 48'(-rd_d) : rd_d;
    den     = {1'b0, num} + {1'b0, nmag};
    if (nrm_j == ONE_POS) begin
      mid_j = sat32({plane_d[47], plane_d});
    end else if (nrm_j == ONE_NEG) begin
      mid_j = sat32(-{plane_d[47], plane_d});
    end else begin
      mid_j = cur_j + prod[47:16];
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_PJ_MUL: begin
        mul_a = {vsel[31], vsel};
        mul_b = pmode ? {{15{nrm_j[17]}}, nrm_j} : {axis_j[31], axis_j};
      end
      S_SQ_MUL: begin
        mul_a = {axis_j[31], axis_j};
        mul_b = {axis_j[31], axis_j};
      end
      S_MID_MUL: begin
        mul_a = {17'd0, frac};
        mul_b = {vsel[31], vsel} - {cur_j[31], cur_j};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    dv_cmd = '0;
    dv_cmd.start = !dv_run && ((state == S_SQRT) || (state == S_NRM) ||
                               (state == S_DIST) || (state == S_FRAC));
    unique case (state)
      S_SQRT: begin
        dv_cmd.sqrt_mode = 1'b1;
        dv_cmd.dividend  = {sq, 1'b0};
        dv_cmd.steps     = SQRT_STEPS;
      end
      S_NRM: begin
        dv_cmd.dividend = {axis_mag, 33'd0};
        dv_cmd.divisor  = {17'd0, len};
        dv_cmd.steps    = NRM_STEPS;
      end
      S_DIST: begin
        dv_cmd.dividend = {tmag, 16'd0};
        dv_cmd.divisor  = {17'd0, len};
        dv_cmd.steps    = DIST_STEPS;
      end
      S_FRAC: begin
        dv_cmd.rem_init = {2'b00, num};
        dv_cmd.divisor  = den;
        dv_cmd.steps    = FRAC_STEPS;
      end
      default: begin
        dv_cmd.steps = '0;
      end
    endcase
  end

  // Vertex, distance and side stores: one write and one registered read.
  assign ld_we = (state == S_LOAD) && vert_valid && (vcount < CNT_W'(MAX_VERTS));
  assign cl_we = (state == S_PJ_DONE) && pmode;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      vx_mem[vcount[ADDR_W-1:0]] <= vert_item.vert_x;
      vy_mem[vcount[ADDR_W-1:0]] <= vert_item.vert_y;
      vz_mem[vcount[ADDR_W-1:0]] <= vert_item.vert_z;
    end
    if (cl_we) begin
      dist_mem[idx] <= dval;
      side_mem[idx] <= cl_side;
    end
    rx   <= vx_mem[ra];
    ry   <= vy_mem[ra];
    rz   <= vz_mem[ra];
    rd_d <= dist_mem[ra];
    rs   <= side_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      vcount    <= '0;
      res_valid <= 1'b0;
      dv_run    <= 1'b0;
      ax        <= '0;
      ay        <= '0;
      az        <= '0;
      mn        <= '0;
      mx        <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (vert_valid) begin
            if (vcount == '0) begin
              ax <= vert_item.axis_x;
              ay <= vert_item.axis_y;
              az <= vert_item.axis_z;
            end
            vcount <= vcount_inc;
            if (vert_item.last_vertex) begin
              nv     <= vcount_inc;
              vcount <= '0;
              if (vcount_inc < CNT_W'(3)) begin
                res_item  <= '{side: 1'b0, out_x: '0, out_y: '0, out_z: '0,
                               status: ST_FEW, last_result: 1'b1};
                res_valid <= 1'b1;
                ret       <= S_LOAD;
                state     <= S_OWAIT;
              end else begin
                idx   <= '0;
                pmode <= 1'b0;
                mn    <= S48_MAX;
                mx    <= ~S48_MAX;
                state <= S_PJ_ADDR;
              end
            end
          end
        end
        S_PJ_ADDR: begin
          ra    <= idx;
          state <= S_PJ_WAIT;
        end
        S_PJ_WAIT: begin
          acc   <= '0;
          j     <= 2'd0;
          state <= S_PJ_MUL;
        end
        S_PJ_MUL: begin
          state <= S_PJ_ACC;
        end
        S_PJ_ACC: begin
          acc <= acc + {prod[65], prod[65:16]};
          if (j == 2'd2) begin
            state <= S_PJ_DONE;
          end else begin
            j     <= j + 2'd1;
            state <= S_PJ_MUL;
          end
        end
        S_PJ_DONE: begin
          if (!pmode) begin
            if (pv < mn) begin
              mn <= pv;
            end
            if (pv > mx) begin
              mx <= pv;
            end
          end else begin
            cnt0 <= cnt0 + LCNT_W'(cl_side != SIDE_BACK) + LCNT_W'(pair_x);
            cnt1 <= cnt1 + LCNT_W'(cl_side != SIDE_FRONT) + LCNT_W'(pair_x);
            fseen <= fseen | (cl_side == SIDE_FRONT);
            bseen <= bseen | (cl_side == SIDE_BACK);
            prev_side <= cl_side;
            if (idx == '0) begin
              first_side <= cl_side;
            end
          end
          if (CNT_W'(idx) == last_idx) begin
            state <= pmode ? S_CL_END : S_SPAN_CHK;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_PJ_ADDR;
          end
        end
        S_SPAN_CHK: begin
          if (span_w <= SPAN_LIMIT) begin
            res_item  <= '{side: 1'b0, out_x: '0, out_y: '0, out_z: '0,
                           status: ST_SPAN, last_result: 1'b1};
            res_valid <= 1'b1;
            ret       <= S_LOAD;
            state     <= S_OWAIT;
          end else begin
            sq    <= '0;
            j     <= 2'd0;
            state <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: begin
          state <= S_SQ_ACC;
        end
        S_SQ_ACC: begin
          sq <= sq + prod[63:0];
          if (j == 2'd2) begin
            state <= S_SQRT;
          end else begin
            j     <= j + 2'd1;
            state <= S_SQ_MUL;
          end
        end
        S_SQRT: begin
          if (!dv_run) begin
            dv_run <= 1'b1;
          end else if (dv_done) begin
            dv_run <= 1'b0;
            len    <= dv_quot[31:0];
            if (dv_quot[31:0] == '0) begin
              res_item  <= '{side: 1'b0, out_x: '0, out_y: '0, out_z: '0,
                             status: ST_SPAN, last_result: 1'b1};
              res_valid <= 1'b1;
              ret       <= S_LOAD;
              state     <= S_OWAIT;
            end else begin
              j     <= 2'd0;
              state <= S_NRM;
            end
          end
        end
        S_NRM: begin
          if (!dv_run) begin
            dv_run <= 1'b1;
          end else if (dv_done) begin
            dv_run <= 1'b0;
            unique case (j)
              2'd0: nrm_x <= axis_j[31] ? -$signed(dv_quot[17:0]) : $signed(dv_quot[17:0]);
              2'd1: nrm_y <= axis_j[31] ? -$signed(dv_quot[17:0]) : $signed(dv_quot[17:0]);
              default: nrm_z <= axis_j[31] ? -$signed(dv_quot[17:0]) : $signed(dv_quot[17:0]);
            endcase
            if (j == 2'd2) begin
              state <= S_DIST;
            end else begin
              j <= j + 2'd1;
            end
          end
        end
        S_DIST: begin
          if (!dv_run) begin
            dv_run <= 1'b1;
          end else if (dv_done) begin
            dv_run  <= 1'b0;
            plane_d <= t_w[48] ? -dpos : dpos;
            pmode   <= 1'b1;
            idx     <= '0;
            cnt0    <= '0;
            cnt1    <= '0;
            fseen   <= 1'b0;
            bseen   <= 1'b0;
            state   <= S_PJ_ADDR;
          end
        end
        S_CL_END: begin
          // Closing edge from the last vertex back to the first.
          if (crosses(prev_side, first_side)) begin
            cnt0 <= cnt0 + 1'b1;
            cnt1 <= cnt1 + 1'b1;
          end
          state <= S_CL_CHK;
        end
        S_CL_CHK: begin
          if (!fseen || !bseen) begin
            res_item  <= '{side: 1'b0, out_x: '0, out_y: '0, out_z: '0,
                           status: ST_ONE, last_result: 1'b1};
            res_valid <= 1'b1;
            ret       <= S_LOAD;
            state     <= S_OWAIT;
          end else if ((cnt0 < LCNT_W'(3)) || (cnt1 < LCNT_W'(3))) begin
            res_item  <= '{side: 1'b0, out_x: '0, out_y: '0, out_z: '0,
                           status: ST_THIN, last_result: 1'b1};
            res_valid <= 1'b1;
            ret       <= S_LOAD;
            state     <= S_OWAIT;
          end else begin
            total <= cnt0 + cnt1;
            k     <= '0;
            lst   <= 1'b0;
            idx   <= '0;
            state <= S_EM_ADDR;
          end
        end
        S_EM_ADDR: begin
          ra    <= idx;
          state <= S_EM_W1;
        end
        S_EM_W1: begin
          state <= S_EM_CUR;
        end
        S_EM_CUR: begin
          cur_x <= rx;
          cur_y <= ry;
          cur_z <= rz;
          cur_d <= rd_d;
          cur_s <= rs;
          ra    <= nx;
          state <= S_EM_W2;
        end
        S_EM_W2: begin
          state <= S_EM_SELF;
        end
        S_EM_SELF: begin
          if (own) begin
            res_item  <= '{side: lst, out_x: cur_x, out_y: cur_y, out_z: cur_z,
                           status: ST_SPLIT, last_result: is_last};
            res_valid <= 1'b1;
            k         <= k + 1'b1;
            ret       <= is_last ? S_LOAD : S_EM_X;
            state     <= S_OWAIT;
          end else begin
            state <= S_EM_X;
          end
        end
        S_EM_X: begin
          state <= crosses(cur_s, rs) ? S_FRAC : S_EM_NEXT;
        end
        S_FRAC: begin
          if (!dv_run) begin
            dv_run <= 1'b1;
          end else if (dv_done) begin
            dv_run <= 1'b0;
            frac   <= dv_quot[15:0];
            j      <= 2'd0;
            state  <= S_MID_MUL;
          end
        end
        S_MID_MUL: begin
          state <= S_MID_ACC;
        end
        S_MID_ACC: begin
          unique case (j)
            2'd0: mid_x <= mid_j;
            2'd1: mid_y <= mid_j;
            default: mid_z <= mid_j;
          endcase
          if (j == 2'd2) begin
            state <= S_EM_MID;
          end else begin
            j     <= j + 2'd1;
            state <= S_MID_MUL;
          end
        end
        S_EM_MID: begin
          res_item  <= '{side: lst, out_x: mid_x, out_y: mid_y, out_z: mid_z,
                         status: ST_SPLIT, last_result: is_last};
          res_valid <= 1'b1;
          k         <= k + 1'b1;
          ret       <= is_last ? S_LOAD : S_EM_NEXT;
          state     <= S_OWAIT;
        end
        S_EM_NEXT: begin
          if (CNT_W'(idx) == last_idx) begin
            idx   <= '0;
            lst   <= 1'b1;
            state <= lst ? S_LOAD : S_EM_ADDR;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_EM_ADDR;
          end
        end
        S_OWAIT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= ret;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(vert_ready && res_valid))
    else $error("vertex load overlaps a pending result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    vcount <= CNT_W'(MAX_VERTS))
    else $error("vertex count past store depth");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.status != ST_SPLIT) |-> res_item.last_result)
    else $error("status item not marked last");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state == S_LOAD) && !res_valid)
    else $error("sequencer not idle after reset");
`endif

endmodule

// ===== tb/sv/tb_polygon_plane_split_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_plane_split_top: testbench for the polygon plane splitter
// Feeds polygons vertex by vertex, predicts the front and back polygons or
// the status item in Q16.16, and compares every result item field by field.
// ----------------------------------------------------------------------------
module tb_polygon_plane_split_top;
  import pps_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam longint Q = 65536;
  localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint MAX32 = 64'sh7FFF_FFFF;

  typedef struct {
    vert_t vert;
    bit    drain;
  } pend_t;

  logic  clk;
  logic  rst;
  logic  vert_valid;
  logic  vert_ready;
  vert_t vert_item;
  logic  res_valid;
  logic  res_ready;
  res_t  res_item;

  pend_t  vert_queue[$];
  res_t   expected_res[$];
  int     mismatches;
  int     idle_cycles;
  int     send_gap;
  int     recv_stall;
  bit     send_burst;
  bit     recv_burst;
  bit     vert_took;
  bit     res_took;

  // Splitter state as the block keeps it.
  longint poly_x[MAX_VERTS];
  longint poly_y[MAX_VERTS];
  longint poly_z[MAX_VERTS];
  longint poly_axis[3];
  int     poly_count;

  polygon_plane_split_top uut (
    .clk(clk), .rst(rst),
    .vert_valid(vert_valid), .vert_ready(vert_ready), .vert_item(vert_item),
    .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint floor_q(input longint x);
    return x >>> 16;
  endfunction

  function automatic longint clip(input longint x, input longint hi);
    if (x > hi) begin
      return hi;
    end else if (x < -hi - 1) begin
      return -hi - 1;
    end
    return x;
  endfunction

  function automatic longint dot_q(input int i, input longint a, input longint b,
                                   input longint c);
    return clip(floor_q(poly_x[i] * a) + floor_q(poly_y[i] * b) + floor_q(poly_z[i] * c),
                MAX48);
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic res_t status_item(input logic [2:0] code);
    res_t r;
    r = '0;
    r.status = code;
    r.last_result = 1'b1;
    return r;
  endfunction

  task automatic predict_split(input vert_t v);
    int n, fc, bc, nx, total, k, l, j, i, b;
    int cnt[2];
    longint mn, mx, d, t, plane_d, d1, d2;
    longint nrm[3];
    longint p1[3];
    longint p2[3];
    longint mid[3];
    longint dst[MAX_VERTS];
    logic [1:0] sd[MAX_VERTS];
    longint lx[2][48];
    longint ly[2][48];
    longint lz[2][48];
    longint unsigned sq, len, mag, qt, rm, num, den, rem;
    int unsigned frac;
    res_t r;

    if (poly_count == 0) begin
      poly_axis[0] = v.axis_x;
      poly_axis[1] = v.axis_y;
      poly_axis[2] = v.axis_z;
    end
    if (poly_count < MAX_VERTS) begin
      poly_x[poly_count] = v.vert_x;
      poly_y[poly_count] = v.vert_y;
      poly_z[poly_count] = v.vert_z;
      poly_count++;
    end
    if (!v.last_vertex) return;
    n = poly_count;
    poly_count = 0;
    if (n < 3) begin
      expected_res.push_back(status_item(ST_FEW));
      return;
    end

    mn = MAX48;
    mx = -MAX48 - 1;
    for (i = 0; i < n; i++) begin
      d = dot_q(i, poly_axis[0], poly_axis[1], poly_axis[2]);
      if (d < mn) mn = d;
      if (d > mx) mx = d;
    end
    if (mx - mn <= longint'(SPLIT_SPAN) * Q) begin
      expected_res.push_back(status_item(ST_SPAN));
      return;
    end

    sq = 0;
    for (j = 0; j < 3; j++) sq += poly_axis[j] * poly_axis[j];
    len = root64(sq);
    if (len == 0) begin
      expected_res.push_back(status_item(ST_SPAN));
      return;
    end
    for (j = 0; j < 3; j++) nrm[j] = (poly_axis[j] * Q) / longint'(len);

    t = mn + longint'(SPLIT_SPAN - 16) * Q;
    mag = (t < 0) ? -t : t;
    qt = mag / len;
    rm = mag % len;
    if (qt >= (64'd1 << 31)) begin
      plane_d = MAX48;
    end else begin
      plane_d = qt * Q + (rm << 16) / len;
    end
    if (t < 0) plane_d = -plane_d;

    fc = 0;
    bc = 0;
    for (i = 0; i < n; i++) begin
      d = clip(dot_q(i, nrm[0], nrm[1], nrm[2]) - plane_d, MAX48);
      dst[i] = d;
      if (d < -6554) begin
        sd[i] = SIDE_BACK;
        bc++;
      end else if (d > 6554) begin
        sd[i] = SIDE_FRONT;
        fc++;
      end else begin
        sd[i] = SIDE_ON;
      end
    end
    if (fc == 0 || bc == 0) begin
      expected_res.push_back(status_item(ST_ONE));
      return;
    end

    cnt[0] = 0;
    cnt[1] = 0;
    for (i = 0; i < n; i++) begin
      nx = (i + 1 < n) ? i + 1 : 0;
      p1[0] = poly_x[i];
      p1[1] = poly_y[i];
      p1[2] = poly_z[i];
      // An on-plane vertex belongs to both polygons and starts no crossing.
      if (sd[i] == SIDE_ON) begin
        for (l = 0; l < 2; l++) begin
          lx[l][cnt[l]] = p1[0];
          ly[l][cnt[l]] = p1[1];
          lz[l][cnt[l]] = p1[2];
          cnt[l]++;
        end
        continue;
      end
      l = (sd[i] == SIDE_FRONT) ? 0 : 1;
      lx[l][cnt[l]] = p1[0];
      ly[l][cnt[l]] = p1[1];
      lz[l][cnt[l]] = p1[2];
      cnt[l]++;
      if (sd[nx] == SIDE_ON || sd[nx] == sd[i]) continue;

      p2[0] = poly_x[nx];
      p2[1] = poly_y[nx];
      p2[2] = poly_z[nx];
      d1 = dst[i];
      d2 = dst[nx];
      num = (d1 < 0) ? -d1 : d1;
      den = num + ((d2 < 0) ? -d2 : d2);
      rem = num;
      frac = 0;
      for (b = 0; b < 16; b++) begin
        rem = rem << 1;
        frac = frac << 1;
        if (rem >= den) begin
          rem = rem - den;
          frac = frac | 1;
        end
      end
      // A component of the normal that is exactly one snaps to the plane.
      for (j = 0; j < 3; j++) begin
        if (nrm[j] == Q) begin
          mid[j] = clip(plane_d, MAX32);
        end else if (nrm[j] == -Q) begin
          mid[j] = clip(-plane_d, MAX32);
        end else begin
          mid[j] = p1[j] + floor_q(longint'(frac) * (p2[j] - p1[j]));
        end
      end
      for (l = 0; l < 2; l++) begin
        lx[l][cnt[l]] = mid[0];
        ly[l][cnt[l]] = mid[1];
        lz[l][cnt[l]] = mid[2];
        cnt[l]++;
      end
    end
    if (cnt[0] < 3 || cnt[1] < 3) begin
      expected_res.push_back(status_item(ST_THIN));
      return;
    end

    total = cnt[0] + cnt[1];
    if (total > 48) total = 48;
    k = 0;
    for (l = 0; l < 2; l++) begin
      for (i = 0; i < cnt[l] && k < total; i++) begin
        r.side = l[0];
        r.out_x = lx[l][i][31:0];
        r.out_y = ly[l][i][31:0];
        r.out_z = lz[l][i][31:0];
        r.status = ST_SPLIT;
        r.last_result = (k == total - 1);
        expected_res.push_back(r);
        k++;
      end
    end
  endtask

  task automatic add_vertex(input int ax, input int ay, input int az, input int x,
                            input int y, input int z, input bit last, input bit drain);
    pend_t p;
    p.vert.axis_x = ax;
    p.vert.axis_y = ay;
    p.vert.axis_z = az;
    p.vert.vert_x = x;
    p.vert.vert_y = y;
    p.vert.vert_z = z;
    p.vert.last_vertex = last;
    p.drain = drain;
    vert_queue.push_back(p);
  endtask

  function automatic int coord(input bit wide);
    if (wide) return $urandom;
    return int'($urandom_range(0, 1200 * 65536)) - 600 * 65536;
  endfunction

  task automatic add_random_polygon();
    int ax, ay, az, n, i, sel;
    bit wide;
    sel = $urandom_range(0, 9);
    ax = 0;
    ay = 0;
    az = 0;
    if (sel < 4) begin
      // Unit axis along one coordinate, either sign.
      case ($urandom_range(0, 2))
        0: ax = 65536;
        1: ay = 65536;
        default: az = 65536;
      endcase
      if ($urandom_range(0, 1)) begin
        ax = -ax;
        ay = -ay;
        az = -az;
      end
    end else if (sel < 8) begin
      ax = int'($urandom_range(0, 262144)) - 131072;
      ay = int'($urandom_range(0, 262144)) - 131072;
      az = int'($urandom_range(0, 262144)) - 131072;
    end else if (sel == 8) begin
      // Long axis: the plane offset shrinks after normalising, so one-sided polygons appear.
      ax = int'($urandom_range(0, 2000)) << 16;
      ay = int'($urandom_range(0, 2000)) << 16;
      az = $urandom_range(0, 65535);
    end else begin
      ax = $urandom;
      ay = $urandom;
      az = $urandom;
    end
    wide = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) == 0) begin
      n = ($urandom_range(0, 1)) ? $urandom_range(1, 2) : $urandom_range(17, 18);
    end else begin
      n = $urandom_range(3, 16);
    end
    for (i = 0; i < n; i++) begin
      if (i == 0) begin
        add_vertex(ax, ay, az, coord(wide), coord(wide), coord(wide), n == 1,
                   $urandom_range(0, 9) == 0);
      end else begin
        add_vertex($urandom, $urandom, $urandom, coord(wide), coord(wide), coord(wide),
                   i == n - 1, 1'b0);
      end
    end
  endtask

  // Sender: inputs change on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      vert_valid <= 1'b0;
    end else if (vert_valid && !vert_took) begin
      vert_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      vert_valid <= 1'b0;
    end else if (vert_queue.size() != 0 &&
                 !(vert_queue[0].drain && expected_res.size() != 0)) begin
      vert_item <= vert_queue[0].vert;
      if (vert_queue[0].vert.last_vertex && $urandom_range(0, 3) == 0) begin
        send_burst <= ~send_burst;
      end
      void'(vert_queue.pop_front());
      vert_valid <= 1'b1;
      send_gap <= send_burst ? 0 : $urandom_range(0, 18);
    end else begin
      vert_valid <= 1'b0;
    end
  end

  // Receiver: a fresh stall is drawn for every result item.
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (res_took) begin
      if ($urandom_range(0, 40) == 0) recv_burst <= ~recv_burst;
      recv_stall <= recv_burst ? 0 : $urandom_range(0, 18);
      res_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    vert_took = !rst && vert_valid && vert_ready;
    res_took = !rst && res_valid && res_ready;
    if (vert_took) predict_split(vert_item);
    if (res_took) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", res_item);
      end else begin
        want = expected_res.pop_front();
        if (res_item !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected side %0d xyz %0d %0d %0d status %0d last %0d",
                     want.side, want.out_x, want.out_y, want.out_z, want.status,
                     want.last_result);
            $display("          actual   side %0d xyz %0d %0d %0d status %0d last %0d",
                     res_item.side, res_item.out_x, res_item.out_y, res_item.out_z,
                     res_item.status, res_item.last_result);
          end
        end
      end
    end
    if (vert_took || res_took || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("polygon_plane_split_top test failed");
        $finish;
      end
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    vert_valid = 1'b0;
    vert_item = '0;
    res_ready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    send_gap = 0;
    recv_stall = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    vert_took = 1'b0;
    res_took = 1'b0;
    poly_count = 0;
    poly_axis = '{0, 0, 0};

    // Two vertices at the field extremes: too few to split.
    add_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0);
    add_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b0);
    // Zero axis.
    add_vertex(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    add_vertex(0, 0, 0, 900 << 16, 0, 0, 1'b0, 1'b0);
    add_vertex(0, 0, 0, 0, 900 << 16, 0, 1'b1, 1'b0);
    // Unit x axis with two vertices lying exactly on the plane.
    add_vertex(65536, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    add_vertex(0, 0, 0, 224 << 16, 100 << 16, 5, 1'b0, 1'b0);
    add_vertex(0, 0, 0, 500 << 16, 0, 7 << 16, 1'b0, 1'b0);
    add_vertex(0, 0, 0, 224 << 16, -(100 << 16), 3, 1'b1, 1'b0);
    // Negative unit y axis: crossings snap to the negated plane distance.
    add_vertex(0, -65536, 0, 10 << 16, 0, 1, 1'b0, 1'b0);
    add_vertex(0, 0, 0, 20 << 16, -(500 << 16), 2, 1'b0, 1'b0);
    add_vertex(0, 0, 0, 30 << 16, -(100 << 16), 3, 1'b1, 1'b0);
    // Sixteen alternating vertices fill every output slot; the extra is dropped.
    for (i = 0; i < 17; i++) begin
      add_vertex(65536, 0, 0, (i % 2) ? (500 << 16) : 0, i << 16, 12345 * i, i == 16,
                 1'b0);
    end

    // The first random polygon waits for the directed results to drain.
    add_random_polygon();
    vert_queue[29].drain = 1'b1;
    while (vert_queue.size() < 270) add_random_polygon();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (vert_queue.size() == 0 && !vert_valid && expected_res.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("polygon_plane_split_top test passed");
    end else begin
      $display("polygon_plane_split_top test failed");
    end
    $finish;
  end

endmodule

// ===== polygon_plane_split_top.f =====
hw/rtl/pps_pkg.sv
hw/rtl/pps_divsqrt.sv
hw/rtl/polygon_plane_split_top.sv
tb/sv/tb_polygon_plane_split_top.sv
